// ===== design/sra_pkg.sv =====
// ----------------------------------------------------------------------------
// sra_pkg
// Shared types and constants for the segment reorder / ACK engine.
// ----------------------------------------------------------------------------
package sra_pkg;

	localparam int SEQ_W = 32;
	localparam int LEN_W = 11;
	localparam int PORT_W = 16;
	localparam int BUF_DEPTH_DEF = 16;
	localparam int MAX_SEG_DEF = 1024;

	typedef enum logic [1:0] {
		CLS_BAD,
		CLS_INORDER,
		CLS_AHEAD,
		CLS_OLD
	} cls_t;

	localparam logic KIND_DELIVER = 1'b0;
	localparam logic KIND_ACK = 1'b1;

	// request handed from front to back
	typedef struct packed {
		cls_t               cls;
		logic [SEQ_W-1:0]   seq;
		logic [LEN_W-1:0]   len;
		logic               fin;
		logic [PORT_W-1:0]  sport;
		logic [PORT_W-1:0]  dport;
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DELIV,
		ST_SCAN,
		ST_STORE,
		ST_ACK
	} state_t;

endpackage

// ===== design/segment_reorder_ack.sv =====
// ----------------------------------------------------------------------------
// segment_reorder_ack
// Receive-side segment reorder engine with cumulative ACK generation.
//
//   channel  | handshake            | payload
//   input    | start / busy         | seg_seq payload_len fin checksum_ok seg_sport seg_dport
//   result   | strobe (no stall)    | kind out_seq out_len ack_* stream_done last
//
// The back part takes a request through queue pop, classify/store and ACK
// states. An in-order request also passes DELIV for its own segment and SCAN
// for each buffered segment it releases, ending with a slot compare that finds
// no match. Each result is registered and leaves in the cycle after its state.
// The two-entry queue lets a request be taken while the back part still works.
// Reset clears next_expected, FIN and all slot valid bits.
// ----------------------------------------------------------------------------
module segment_reorder_ack import sra_pkg::*; #(
	parameter int BUF_DEPTH = BUF_DEPTH_DEF,
	parameter int MAX_SEG = MAX_SEG_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [SEQ_W-1:0]  seg_seq,
	input  logic [LEN_W-1:0]  payload_len,
	input  logic              fin,
	input  logic              checksum_ok,
	input  logic [PORT_W-1:0] seg_sport,
	input  logic [PORT_W-1:0] seg_dport,
	output logic              strobe,
	output logic              kind,
	output logic [SEQ_W-1:0]  out_seq,
	output logic [LEN_W-1:0]  out_len,
	output logic [SEQ_W-1:0]  ack_number,
	output logic [PORT_W-1:0] ack_sport,
	output logic [PORT_W-1:0] ack_dport,
	output logic              stream_done,
	output logic              last
);

	logic full, q_valid, pop, idle, push;
	req_t q_req;

	assign busy = full;
	assign push = start && !full;

	sra_front #(.MAX_SEG(MAX_SEG)) u_front (
		.clk, .arst_n, .push, .seg_seq, .payload_len, .fin, .checksum_ok,
		.seg_sport, .seg_dport, .full, .q_valid, .q_req, .pop
	);

	sra_back #(.BUF_DEPTH(BUF_DEPTH)) u_back (
		.clk, .arst_n, .q_valid, .q_req, .pop, .idle, .strobe, .kind, .out_seq,
		.out_len, .ack_number, .ack_sport, .ack_dport, .stream_done, .last
	);

	a_last_is_ack: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> kind == KIND_ACK) else $error("last without ACK");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> idle) else $error("pop while back busy");
	a_deliver_zero_ack: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind == KIND_DELIVER |-> ack_number == '0 && !last)
		else $error("deliver carries ACK fields");

endmodule

// ===== design/sra_front.sv =====
// ----------------------------------------------------------------------------
// sra_front
// Takes segment descriptors, clamps length, holds them in a short queue.
// ----------------------------------------------------------------------------
module sra_front import sra_pkg::*; #(
	parameter int MAX_SEG = MAX_SEG_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [SEQ_W-1:0]  seg_seq,
	input  logic [LEN_W-1:0]  payload_len,
	input  logic              fin,
	input  logic              checksum_ok,
	input  logic [PORT_W-1:0] seg_sport,
	input  logic [PORT_W-1:0] seg_dport,
	output logic              full,
	output logic              q_valid,
	output req_t              q_req,
	input  logic              pop
);

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_SEG);

	req_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	req_t       new_req;

	always_comb begin
		new_req.cls = checksum_ok ? CLS_INORDER : CLS_BAD;  // ordering decided in back
		new_req.seq = seg_seq;
		new_req.len = (payload_len > MAX_LEN) ? MAX_LEN : payload_len;
		new_req.fin = fin;
		new_req.sport = seg_sport;
		new_req.dport = seg_dport;
	end

	assign full = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_req = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= new_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== design/sra_back.sv =====
// ----------------------------------------------------------------------------
// sra_back
// Reorder buffer, cumulative ACK state and result sequencer.
// ----------------------------------------------------------------------------
module sra_back import sra_pkg::*; #(
	parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  req_t              q_req,
	output logic              pop,
	output logic              idle,
	output logic              strobe,
	output logic              kind,
	output logic [SEQ_W-1:0]  out_seq,
	output logic [LEN_W-1:0]  out_len,
	output logic [SEQ_W-1:0]  ack_number,
	output logic [PORT_W-1:0] ack_sport,
	output logic [PORT_W-1:0] ack_dport,
	output logic              stream_done,
	output logic              last
);

	localparam int IW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

	state_t state_q, state_d;
	req_t   cur_q;
	logic [SEQ_W-1:0] nexp_q;
	logic             fin_seen_q;
	logic [BUF_DEPTH-1:0] valid_q;
	logic [SEQ_W-1:0] slot_seq_q [BUF_DEPTH];
	logic [LEN_W-1:0] slot_len_q [BUF_DEPTH];

	// match / free search over all slots (parallel compare, priority pick)
	logic [BUF_DEPTH-1:0] hit;
	logic             hit_any, dup, free_any;
	logic [IW-1:0]    hit_idx, free_idx;
	logic [SEQ_W-1:0] key, diff;

	assign key = (state_q == ST_SCAN) ? nexp_q : cur_q.seq;
	assign diff = cur_q.seq - nexp_q;

	always_comb begin
		hit_any = 1'b0;
		free_any = 1'b0;
		hit_idx = '0;
		free_idx = '0;
		for (int i = BUF_DEPTH - 1; i >= 0; i--) begin
			hit[i] = valid_q[i] && (slot_seq_q[i] == key);
			if (hit[i]) begin
				hit_any = 1'b1;
				hit_idx = IW'(i);
			end
			if (!valid_q[i]) begin
				free_any = 1'b1;
				free_idx = IW'(i);
			end
		end
		dup = hit_any;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (q_valid) state_d = ST_STORE;
			ST_STORE: begin
				// classify against current next_expected
				if (cur_q.cls == CLS_BAD) state_d = ST_ACK;
				else if (diff == '0) state_d = ST_DELIV;
				else state_d = ST_ACK;
			end
			ST_DELIV: state_d = ST_SCAN;
			ST_SCAN:  state_d = hit_any ? ST_SCAN : ST_ACK;
			ST_ACK:   state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	assign pop = (state_q == ST_IDLE) && q_valid;
	assign idle = (state_q == ST_IDLE);

	always_ff @(posedge clk) begin
		if (pop) cur_q <= q_req;
		if (state_q == ST_STORE && cur_q.cls != CLS_BAD && diff != '0 &&
		    !diff[SEQ_W-1] && !dup && free_any) begin
			slot_seq_q[free_idx] <= cur_q.seq;
			slot_len_q[free_idx] <= cur_q.len;
		end
		out_seq <= '0;
		out_len <= '0;
		ack_number <= '0;
		ack_sport <= '0;
		ack_dport <= '0;
		kind <= KIND_DELIVER;
		last <= 1'b0;
		stream_done <= 1'b0;
		if (state_q == ST_DELIV) begin
			out_seq <= cur_q.seq;
			out_len <= cur_q.len;
		end else if (state_q == ST_SCAN && hit_any) begin
			out_seq <= slot_seq_q[hit_idx];
			out_len <= slot_len_q[hit_idx];
		end else if (state_q == ST_ACK) begin
			kind <= KIND_ACK;
			last <= 1'b1;
			ack_number <= nexp_q;
			ack_sport <= cur_q.dport;
			ack_dport <= cur_q.sport;
			stream_done <= fin_seen_q && (valid_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			nexp_q <= '0;
			fin_seen_q <= 1'b0;
			valid_q <= '0;
			strobe <= 1'b0;
		end else begin
			state_q <= state_d;
			strobe <= (state_q == ST_DELIV) || (state_q == ST_SCAN && hit_any) ||
			          (state_q == ST_ACK);
			if (state_q == ST_STORE && cur_q.cls != CLS_BAD) begin
				if (cur_q.fin) fin_seen_q <= 1'b1;
				if (diff != '0 && !diff[SEQ_W-1] && !dup && free_any)
					valid_q[free_idx] <= 1'b1;
			end
			if (state_q == ST_DELIV) nexp_q <= nexp_q + SEQ_W'(cur_q.len);
			if (state_q == ST_SCAN && hit_any) begin
				nexp_q <= nexp_q + SEQ_W'(slot_len_q[hit_idx]);
				valid_q[hit_idx] <= 1'b0;
			end
		end
	end

endmodule
